// ----- rtl/core/med3_pkg.sv -----
// ----------------------------------------------------------------------------
// med3_pkg
// Shared types and constants for the 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package med3_pkg;

    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 7;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int WIN        = 9;
    localparam int SORT_ROUNDS = 9;
    localparam int CNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 7'd28;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 12'd28;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [PIX_W:0]   key_t;      // {invalid, value}
    typedef key_t [WIN-1:0]   key_vec_t;
    typedef pix_t [WIN-1:0]   win_t;

    typedef struct packed {
        logic                 load;
        logic                 emit;
        logic                 pre;
        logic                 is_final;
        logic [WIN-1:0]       mask;
        logic [CNT_W-1:0]     cnt;
    } s1_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/median_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit grayscale frames.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per clock once primed,
// while the output is not stalled. Results lag input by one row plus one
// pixel; drain requests (tuser = 1) after the last pixel flush the tail, and
// the last result of a frame has tlast set. The accepting edge starts the
// line-store RAM read; the window update then completes together with the
// first of nine odd-even transposition sort stages, and the output register
// follows the last stage. Every stage holds while the output is stalled.
// Both line stores share one RAM with one read and one write per cycle; a
// write followed by a read of the same column is forwarded.
`default_nettype none

module median_filter_3x3 #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [7:0] pixel_in
    input  logic                                  s_tuser,   // [0] cmd
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,   // [7:0] pixel_out
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [med3_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [med3_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import med3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;

    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [ROW_W-1:0]   height_reg, height_next;
    logic [AW-1:0]      icol_reg, icol_next;
    logic [ROW_W-1:0]   irow_reg, irow_next;
    logic [AW-1:0]      ocol_reg, ocol_next;
    logic [ROW_W-1:0]   orow_reg, orow_next;
    logic               primed_reg, primed_next;

    logic [EW-1:0]      width_ext;
    logic [AW-1:0]      wm1;
    logic [ROW_W-1:0]   hm1;
    logic               adv, accept, in_drain, ignore, is_final, pre, cfg_wr;
    logic [2:0]         row_ok, col_ok;
    logic [WIN-1:0]     mask;
    pix_t               pix_eff;

    logic               s1_valid_reg;
    s1_ctl_t            s1_ctl_reg, s1_ctl_next;
    pix_t               s1_pix_reg;
    logic [AW-1:0]      s1_addr_reg;

    logic               hold_valid_reg;
    logic [AW-1:0]      hold_addr_reg;
    logic [2*PIX_W-1:0] hold_data_reg;
    logic [2*PIX_W-1:0] rd_data, line_data, wr_data;
    logic               wr_en;

    win_t               win_reg, win_after, win_sel;
    key_vec_t           keys;

    key_vec_t           srt_reg [SORT_ROUNDS];
    logic               srt_valid_reg [SORT_ROUNDS];
    logic               srt_last_reg [SORT_ROUNDS];
    logic [CNT_W-1:0]   srt_cnt_reg [SORT_ROUNDS];

    pix_t               lo_val, hi_val;
    logic [PIX_W:0]     pair_sum;
    logic               m_tvalid_reg;
    pix_t               m_tdata_reg;
    logic               m_tlast_reg;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    assign width_ext = EW'(width_reg);

    always_comb
    begin
        if (width_reg == '0)
        begin
            wm1 = '0;
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            wm1 = AW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = AW'(width_ext - EW'(1));
        end
    end

    assign hm1      = (height_reg == '0) ? '0 : height_reg - ROW_W'(1);
    assign in_drain = irow_reg > hm1;
    assign ignore   = !in_drain && (s_tuser == CMD_DRAIN);
    assign pre      = primed_reg && (ocol_reg == wm1);
    assign is_final = pre && (orow_reg == hm1);
    assign pix_eff  = in_drain ? '0 : s_tdata;

    // neighbourhood mask, window row r (top first), column c
    assign row_ok = {orow_reg != hm1, 1'b1, orow_reg != '0};
    assign col_ok = pre ? {1'b1, ocol_reg != '0, 1'b0}
                        : {ocol_reg != wm1, 1'b1, ocol_reg != '0};

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mask[r*3 + c] = row_ok[r] && col_ok[c];
            end
        end
    end

    always_comb
    begin
        s1_ctl_next.load     = !is_final;
        s1_ctl_next.emit     = primed_reg;
        s1_ctl_next.pre      = pre;
        s1_ctl_next.is_final = is_final;
        s1_ctl_next.mask     = mask;
        s1_ctl_next.cnt      = CNT_W'($countones(mask));
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        icol_next   = icol_reg;
        irow_next   = irow_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        primed_next = primed_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_next  = cfg_data[WIDTH_W-1:0];
                    icol_next   = '0;
                    irow_next   = '0;
                    ocol_next   = '0;
                    orow_next   = '0;
                    primed_next = 1'b0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data;
                    icol_next   = '0;
                    irow_next   = '0;
                    ocol_next   = '0;
                    orow_next   = '0;
                    primed_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept && !ignore)
        begin
            if (is_final)
            begin
                icol_next   = '0;
                irow_next   = '0;
                ocol_next   = '0;
                orow_next   = '0;
                primed_next = 1'b0;
            end
            else
            begin
                if (primed_reg)
                begin
                    if (ocol_reg == wm1)
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + ROW_W'(1);
                    end
                    else
                    begin
                        ocol_next = ocol_reg + AW'(1);
                    end
                end
                if (irow_reg != '0)
                begin
                    primed_next = 1'b1;
                end
                if (!(in_drain && icol_reg == wm1))
                begin
                    if (icol_reg == wm1)
                    begin
                        icol_next = '0;
                        irow_next = irow_reg + ROW_W'(1);
                    end
                    else
                    begin
                        icol_next = icol_reg + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            icol_reg   <= '0;
            irow_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            icol_reg   <= icol_next;
            irow_reg   <= irow_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
            primed_reg <= primed_next;
        end
    end

    // line stores: {upper, lower} per column
    med3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (icol_reg),
        .rd_data (rd_data)
    );

    assign line_data = (hold_valid_reg && hold_addr_reg == s1_addr_reg) ? hold_data_reg
                                                                         : rd_data;
    assign wr_data = {line_data[PIX_W-1:0], s1_pix_reg};
    assign wr_en   = adv && s1_valid_reg && s1_ctl_reg.load;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_after[r*3]     = win_reg[r*3 + 1];
            win_after[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_after[2] = line_data[2*PIX_W-1:PIX_W];
        win_after[5] = line_data[PIX_W-1:0];
        win_after[8] = s1_pix_reg;
        win_sel = s1_ctl_reg.pre ? win_reg : win_after;
        for (int i = 0; i < WIN; i++)
        begin
            keys[i] = s1_ctl_reg.mask[i] ? {1'b0, win_sel[i]} : {1'b1, {PIX_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            win_reg        <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg   <= accept && !ignore;
                hold_valid_reg <= s1_valid_reg && s1_ctl_reg.load;
            end
            if (cfg_wr && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT))
            begin
                win_reg <= '0;
            end
            else if (adv && s1_valid_reg)
            begin
                win_reg <= s1_ctl_reg.is_final ? '0 : win_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg    <= s1_ctl_next;
            s1_pix_reg    <= pix_eff;
            s1_addr_reg   <= icol_reg;
            hold_addr_reg <= s1_addr_reg;
            hold_data_reg <= wr_data;
        end
    end

    // odd-even transposition sort, one round per stage
    for (genvar k = 0; k < SORT_ROUNDS; k++)
    begin : g_round
        key_vec_t         rin, rout;
        logic             vin, lin;
        logic [CNT_W-1:0] cin;

        if (k == 0)
        begin : g_first
            assign rin = keys;
            assign vin = s1_valid_reg && s1_ctl_reg.emit;
            assign lin = s1_ctl_reg.is_final;
            assign cin = s1_ctl_reg.cnt;
        end
        else
        begin : g_next
            assign rin = srt_reg[k-1];
            assign vin = srt_valid_reg[k-1];
            assign lin = srt_last_reg[k-1];
            assign cin = srt_cnt_reg[k-1];
        end

        always_comb
        begin
            rout = rin;
            for (int i = k % 2; i + 1 < WIN; i += 2)
            begin
                if (rin[i] > rin[i+1])
                begin
                    rout[i]   = rin[i+1];
                    rout[i+1] = rin[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                srt_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                srt_valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                srt_reg[k]      <= rout;
                srt_last_reg[k] <= lin;
                srt_cnt_reg[k]  <= cin;
            end
        end
    end

    always_comb
    begin
        lo_val = srt_reg[SORT_ROUNDS-1][0][PIX_W-1:0];
        hi_val = srt_reg[SORT_ROUNDS-1][0][PIX_W-1:0];
        case (srt_cnt_reg[SORT_ROUNDS-1])
            4'd2:
            begin
                lo_val = srt_reg[SORT_ROUNDS-1][0][PIX_W-1:0];
                hi_val = srt_reg[SORT_ROUNDS-1][1][PIX_W-1:0];
            end
            4'd3:
            begin
                lo_val = srt_reg[SORT_ROUNDS-1][1][PIX_W-1:0];
                hi_val = srt_reg[SORT_ROUNDS-1][1][PIX_W-1:0];
            end
            4'd4:
            begin
                lo_val = srt_reg[SORT_ROUNDS-1][1][PIX_W-1:0];
                hi_val = srt_reg[SORT_ROUNDS-1][2][PIX_W-1:0];
            end
            4'd5:
            begin
                lo_val = srt_reg[SORT_ROUNDS-1][2][PIX_W-1:0];
                hi_val = srt_reg[SORT_ROUNDS-1][2][PIX_W-1:0];
            end
            4'd6:
            begin
                lo_val = srt_reg[SORT_ROUNDS-1][2][PIX_W-1:0];
                hi_val = srt_reg[SORT_ROUNDS-1][3][PIX_W-1:0];
            end
            4'd7:
            begin
                lo_val = srt_reg[SORT_ROUNDS-1][3][PIX_W-1:0];
                hi_val = srt_reg[SORT_ROUNDS-1][3][PIX_W-1:0];
            end
            4'd8:
            begin
                lo_val = srt_reg[SORT_ROUNDS-1][3][PIX_W-1:0];
                hi_val = srt_reg[SORT_ROUNDS-1][4][PIX_W-1:0];
            end
            4'd9:
            begin
                lo_val = srt_reg[SORT_ROUNDS-1][4][PIX_W-1:0];
                hi_val = srt_reg[SORT_ROUNDS-1][4][PIX_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign pair_sum = {1'b0, lo_val} + {1'b0, hi_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= srt_valid_reg[SORT_ROUNDS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= pair_sum[PIX_W:1];
            m_tlast_reg <= srt_last_reg[SORT_ROUNDS-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ----- rtl/core/med3_ram.sv -----
// ----------------------------------------------------------------------------
// med3_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module med3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/med3_checker.sv -----
// ----------------------------------------------------------------------------
// med3_checker
// Port-level checks for the 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

module med3_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with free output");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind median_filter_3x3 med3_checker u_med3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
